// File: hdl/timestamp_to_epoch_seconds_defines.svh
// Assertion macros for the date-time stamp parser checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef TIMESTAMP_TO_EPOCH_SECONDS_DEFINES_SVH
`define TIMESTAMP_TO_EPOCH_SECONDS_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define TSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Plain overlapping implication on top of the clocked form.
`define TSE_ASSERT_IMP(lbl, ante, cons, msg) \
  `TSE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/tse_pkg.sv
// Shared types and constants for the date-time stamp parser.
// No dependencies.
`default_nettype none

package tse_pkg;

  // Stamp layout "YYYY-MM-DD HH:MM:SS"
  localparam logic [4:0] STAMP_LEN = 5'd19;
  localparam logic [4:0] LAST_POS  = 5'd18;
  localparam logic [4:0] P_YEAR    = 5'd0;
  localparam logic [4:0] P_MON     = 5'd5;
  localparam logic [4:0] P_DAY     = 5'd8;
  localparam logic [4:0] P_HOUR    = 5'd11;
  localparam logic [4:0] P_MIN     = 5'd14;
  localparam logic [4:0] P_SEC     = 5'd17;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Days from 0000-03-01 to 1970-01-01
  localparam logic [23:0] EPOCH_DAYS = 24'd719468;
  localparam logic signed [38:0] DAY_SECS = 39'sd86400;
  // floor(y/100) = (y * 5243) >> 19 for 0 <= y < 16384
  localparam logic [26:0] RECIP100   = 27'd5243;

  localparam logic signed [38:0] SEC_MIN = -39'sd62167219200;
  localparam logic signed [38:0] SEC_MAX = 39'sd253402300800;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;      // character request accepted
    logic [4:0] pos;       // its place in the line
    logic       fail_out;  // load a failure result (line ended early)
    logic       calc1;
    logic       calc2;
    logic       calc3;
    logic       calc4;
    logic       finish;    // load the converted result
  } tse_cmd_t;

endpackage

`default_nettype wire

// File: hdl/tse_ctrl.sv
// Sequencer for the stamp parser: line position, conversion steps, output valid.
// Depends on tse_pkg.
`default_nettype none

module tse_ctrl import tse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     line_end_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output tse_cmd_t cmd_o
);

  localparam logic [2:0] S_PARSE = 3'd0;
  localparam logic [2:0] S_CALC1 = 3'd1;
  localparam logic [2:0] S_CALC2 = 3'd2;
  localparam logic [2:0] S_CALC3 = 3'd3;
  localparam logic [2:0] S_CALC4 = 3'd4;
  localparam logic [2:0] S_CALC5 = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, ends_now, take, early_fail;

  assign out_free   = !out_valid_q || out_ready_i;
  // this request yields a result
  assign ends_now   = (pos_q < STAMP_LEN) && ((pos_q == LAST_POS) || line_end_i);
  assign in_ready_o = (state_q == S_PARSE) && (out_free || !ends_now);
  assign take       = in_valid_i && in_ready_o;
  assign early_fail = take && (pos_q < LAST_POS) && line_end_i;

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      if (line_end_i) begin
        pos_d = 5'd0;
      end else if (pos_q < STAMP_LEN) begin
        pos_d = pos_q + 5'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_PARSE: begin
        if (take && (pos_q == LAST_POS)) begin
          state_d = S_CALC1;
        end
      end
      S_CALC1: state_d = S_CALC2;
      S_CALC2: state_d = S_CALC3;
      S_CALC3: state_d = S_CALC4;
      S_CALC4: state_d = S_CALC5;
      S_CALC5: state_d = S_PARSE;
      default: state_d = S_PARSE;
    endcase
  end

  assign out_valid_d = early_fail || (state_q == S_CALC5) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PARSE;
      pos_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.take     = take;
    cmd_o.pos      = pos_q;
    cmd_o.fail_out = early_fail;
    cmd_o.calc1    = (state_q == S_CALC1);
    cmd_o.calc2    = (state_q == S_CALC2);
    cmd_o.calc3    = (state_q == S_CALC3);
    cmd_o.calc4    = (state_q == S_CALC4);
    cmd_o.finish   = (state_q == S_CALC5);
  end

endmodule

`default_nettype wire

// File: hdl/tse_datapath.sv
// Datapath of the stamp parser: digit accumulators, separator checks,
// days-from-civil conversion and the result register. Depends on tse_pkg.
`default_nettype none

module tse_datapath import tse_pkg::*; (
  input  logic               clk_i,
  input  tse_cmd_t           cmd_i,
  input  logic [7:0]         ch_i,
  output logic               ok_o,
  output logic signed [38:0] seconds_o
);

  // Days from 1 March to the first of each month (March-based year)
  function automatic logic [8:0] month_base(input logic [3:0] mon);
    logic [8:0] b;
    case (mon)
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic        failed_q, failed_d;
  logic        is_dig, bad;
  logic [3:0]  dig;

  // conversion pipeline
  logic signed [14:0] y_q;
  logic [8:0]         doy_q;
  logic [16:0]        tod_q;
  logic               good_q;
  logic [26:0]        prod100;
  logic signed [7:0]  q100_q;
  logic signed [12:0] q4_q;
  logic signed [23:0] y365_q;
  logic signed [23:0] days_q;
  logic signed [38:0] prod_q;
  logic               ok_q;
  logic signed [38:0] sec_q;

  assign is_dig = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig    = ch_i[3:0];

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    bad      = 1'b0;
    case (cmd_i.pos)
      P_YEAR: begin
        bad = !is_dig;
        if (is_dig) year_d = 14'(dig);
      end
      P_YEAR + 5'd1, P_YEAR + 5'd2, P_YEAR + 5'd3: begin
        bad = !is_dig;
        if (is_dig) year_d = 14'(year_q * 14'd10 + 14'(dig));
      end
      P_MON: begin
        bad = !is_dig;
        if (is_dig) month_d = 7'(dig);
      end
      P_MON + 5'd1: begin
        bad = !is_dig;
        if (is_dig) month_d = 7'(month_q * 7'd10 + 7'(dig));
      end
      P_DAY: begin
        bad = !is_dig;
        if (is_dig) day_d = 7'(dig);
      end
      P_DAY + 5'd1: begin
        bad = !is_dig;
        if (is_dig) day_d = 7'(day_q * 7'd10 + 7'(dig));
      end
      P_HOUR: begin
        bad = !is_dig;
        if (is_dig) hour_d = 7'(dig);
      end
      P_HOUR + 5'd1: begin
        bad = !is_dig;
        if (is_dig) hour_d = 7'(hour_q * 7'd10 + 7'(dig));
      end
      P_MIN: begin
        bad = !is_dig;
        if (is_dig) minute_d = 7'(dig);
      end
      P_MIN + 5'd1: begin
        bad = !is_dig;
        if (is_dig) minute_d = 7'(minute_q * 7'd10 + 7'(dig));
      end
      P_SEC: begin
        bad = !is_dig;
        if (is_dig) second_d = 7'(dig);
      end
      P_SEC + 5'd1: begin
        bad = !is_dig;
        if (is_dig) second_d = 7'(second_q * 7'd10 + 7'(dig));
      end
      P_MON - 5'd1, P_DAY - 5'd1: bad = (ch_i != CH_DASH);
      P_HOUR - 5'd1:              bad = (ch_i != CH_SPACE);
      P_MIN - 5'd1, P_SEC - 5'd1: bad = (ch_i != CH_COLON);
      default:                    bad = 1'b0;
    endcase
    // first character of a line restarts the failure flag
    failed_d = (cmd_i.pos == P_YEAR) ? bad : (failed_q | bad);
  end

  assign prod100 = 27'(y_q[13:0]) * RECIP100;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      failed_q <= failed_d;
    end
    if (cmd_i.calc1) begin
      // Jan/Feb count towards the previous year
      y_q    <= $signed(15'(year_q) - 15'(month_q <= 7'd2));
      doy_q  <= month_base(month_q[3:0]) + 9'(day_q) - 9'd1;
      tod_q  <= 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);
      good_q <= !failed_q && (month_q >= 7'd1) && (month_q <= 7'd12)
                && (day_q >= 7'd1) && (day_q <= 7'd31) && (hour_q <= 7'd23)
                && (minute_q <= 7'd59) && (second_q <= 7'd60);
    end
    if (cmd_i.calc2) begin
      // only negative year is -1 (year 0, Jan/Feb)
      q100_q <= y_q[14] ? -8'sd1 : $signed({1'b0, prod100[25:19]});
      q4_q   <= 13'(y_q >>> 2);
      y365_q <= 24'(y_q) * 24'sd365;
    end
    if (cmd_i.calc3) begin
      days_q <= $signed(24'(y365_q) + 24'(q4_q) - 24'(q100_q) + 24'(q100_q >>> 2)
                        + 24'(doy_q) - EPOCH_DAYS);
    end
    if (cmd_i.calc4) begin
      prod_q <= 39'(days_q) * DAY_SECS;
    end
    if (cmd_i.fail_out) begin
      ok_q  <= 1'b0;
      sec_q <= '0;
    end else if (cmd_i.finish) begin
      ok_q  <= good_q;
      sec_q <= good_q ? (prod_q + $signed(39'(tod_q))) : '0;
    end
  end

  assign ok_o      = ok_q;
  assign seconds_o = sec_q;

endmodule

`default_nettype wire

// File: hdl/timestamp_to_epoch_seconds.sv
// Date-time stamp parser: one character a cycle while a line is read, unless the input is held back.
// Failure for a line that ends early is registered the cycle after its last character.
// A stamp's 19th character holds the input back while the conversion runs;
// the result shows once the conversion is done, and no character is taken before then.
// Asynchronous active-low reset returns to the start of a line; no clearing pass.
`default_nettype none

module timestamp_to_epoch_seconds import tse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // character requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               line_end_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic signed [38:0] seconds_o
);

  tse_cmd_t cmd;

  // Controller: tracks the line position, steps the conversion and owns the
  // output valid. No character is taken while the conversion runs; otherwise a
  // request that would yield a result is held back only while the output register
  // is full and not being drained, and other characters flow on.
  tse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .line_end_i  (line_end_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath: accumulates digits, checks separators, then converts through
  // four registered steps (year shift and month table, floor divisions,
  // day count, times 86400) and a final add of the time of day.
  tse_datapath u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .ch_i      (ch_i),
    .ok_o      (ok_o),
    .seconds_o (seconds_o)
  );

endmodule

`default_nettype wire

// File: hdl/tse_sva.sv
// Port-level checker for the date-time stamp parser, bound to the top level.
// Depends on tse_pkg and timestamp_to_epoch_seconds_defines.svh.
`default_nettype none
`include "timestamp_to_epoch_seconds_defines.svh"

module tse_sva import tse_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               ok_o,
  input logic signed [38:0] seconds_o
);

  `TSE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) && $stable(seconds_o), "result dropped or changed while stalled")

  `TSE_ASSERT_IMP(a_fail_zero, out_valid_o && !ok_o, seconds_o == 39'sd0, "failure result carries nonzero seconds")

  `TSE_ASSERT_IMP(a_range, out_valid_o && ok_o, (seconds_o >= SEC_MIN) && (seconds_o <= SEC_MAX), "seconds outside four-digit year range")

endmodule

bind timestamp_to_epoch_seconds tse_sva u_tse_sva (.*);

`default_nettype wire
